FILE: design/ftc_pkg.sv
`default_nettype none
package ftc_pkg;

    localparam int COORD_BITS = 32;
    localparam int ANGLE_BITS = 16;

    localparam int PORT_COORD_W = 32;
    localparam int PORT_ANGLE_W = 16;
    localparam int SCALE_W      = 16;
    localparam int SPROD_W      = 2 * SCALE_W;
    localparam int SCALE_FRAC   = 8;

    // Quarter-wave polynomial, Q14 in, Q15 out
    localparam int QUARTER   = 16384;
    localparam int QW_SH     = 14;
    localparam int QW_RND    = 1 << (QW_SH - 1);
    localparam int QW_C1     = 2320;
    localparam int QW_C2     = 21024;
    localparam int QW_C3     = 51472;
    localparam int QX_W      = QW_SH + 1;
    localparam int TRIG_W    = 17;

    localparam int FRAC_BITS = 23;
    localparam int PROD_W    = COORD_BITS + TRIG_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int LO_W      = SUM_W / 2;
    localparam int HI_W      = SUM_W - LO_W;
    localparam int PLO_W     = SCALE_W + LO_W + 1;
    localparam int PHI_W     = SCALE_W + HI_W;
    localparam int PW        = SUM_W + SCALE_W;
    localparam int RND_W     = PW - FRAC_BITS;
    localparam int RX_W      = RND_W + 1;
    localparam int SAT_W     = RX_W + 1;

    // sincos 4 stages, rotate 5 stages, then the output register
    localparam int SIDE_DEPTH = 9;
    localparam int ROT_TAP    = 3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [TRIG_W-1:0]     t_trig;
    typedef logic signed [SCALE_W-1:0]    t_scale;
    typedef logic signed [RX_W-1:0]       t_rot;

endpackage
`default_nettype wire

FILE: design/ftc_sincos.sv
`default_nettype none
module ftc_sincos import ftc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic [15:0] i_angle,
    output t_trig            o_sin,
    output t_trig            o_cos
);

    logic [15:0]     lane_ang [2];
    logic [QX_W-1:0] n_x      [2];

    logic [QX_W-1:0] r1_x  [2];
    logic [QX_W-1:0] r1_x2 [2];
    logic            r1_neg[2];
    logic [QX_W-1:0] r2_x  [2];
    logic [QX_W-1:0] r2_x2 [2];
    logic [QX_W-1:0] r2_u  [2];
    logic            r2_neg[2];
    logic [QX_W-1:0] r3_x  [2];
    logic [15:0]     r3_w  [2];
    logic            r3_neg[2];
    logic [15:0]     n_p   [2];
    t_trig           n_trig[2];
    t_trig           r_trig[2];

    assign lane_ang[0] = i_angle;
    assign lane_ang[1] = i_angle + 16'(QUARTER);

    // fold odd quadrants onto the rising quarter
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (lane_ang[l][14]) begin
                n_x[l] = QX_W'(QUARTER) - {1'b0, lane_ang[l][13:0]};
            end else begin
                n_x[l] = {1'b0, lane_ang[l][13:0]};
            end
            n_p[l]    = 16'((31'(r3_w[l]) * 31'(r3_x[l]) + 31'(QW_RND)) >> QW_SH);
            n_trig[l] = r3_neg[l] ? -t_trig'({1'b0, n_p[l]}) : t_trig'({1'b0, n_p[l]});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r1_x[l]   <= n_x[l];
            r1_neg[l] <= lane_ang[l][15];
            r1_x2[l]  <= QX_W'((30'(n_x[l]) * 30'(n_x[l]) + 30'(QW_RND)) >> QW_SH);

            r2_x[l]   <= r1_x[l];
            r2_x2[l]  <= r1_x2[l];
            r2_neg[l] <= r1_neg[l];
            r2_u[l]   <= QX_W'(QW_C2)
                         - QX_W'((27'(QW_C1) * 27'(r1_x2[l]) + 27'(QW_RND)) >> QW_SH);

            r3_x[l]   <= r2_x[l];
            r3_neg[l] <= r2_neg[l];
            r3_w[l]   <= 16'(QW_C3)
                         - 16'((30'(r2_u[l]) * 30'(r2_x2[l]) + 30'(QW_RND)) >> QW_SH);

            r_trig[l] <= n_trig[l];
        end
    end

    assign o_sin = r_trig[0];
    assign o_cos = r_trig[1];

endmodule
`default_nettype wire

FILE: design/ftc_rotate.sv
`default_nettype none
module ftc_rotate import ftc_pkg::*; (
    input  wire logic   i_clk,
    input  wire t_coord i_a,
    input  wire t_coord i_b,
    input  wire t_trig  i_ka,
    input  wire t_trig  i_kb,
    input  wire t_scale i_scale,
    output t_rot        o_res
);

    logic signed [PROD_W-1:0] r_pa;
    logic signed [PROD_W-1:0] r_pb;
    t_scale                   r_s1;
    logic signed [SUM_W-1:0]  r_sum;
    t_scale                   r_s2;
    logic signed [PLO_W-1:0]  r_plo;
    logic signed [PHI_W-1:0]  r_phi;
    logic signed [PW-1:0]     r_v;
    t_rot                     r_res;

    logic signed [HI_W-1:0]      sum_hi;
    logic signed [LO_W:0]        sum_lo;
    logic signed [RND_W-1:0]     v_q;
    logic                        v_inc;
    t_rot                        n_res;

    assign sum_hi = r_sum[SUM_W-1:LO_W];
    assign sum_lo = $signed({1'b0, r_sum[LO_W-1:0]});

    // round to nearest, ties to even
    always_comb begin
        v_q   = r_v[PW-1:FRAC_BITS];
        v_inc = r_v[FRAC_BITS-1] & ((|r_v[FRAC_BITS-2:0]) | v_q[0]);
        n_res = RX_W'(v_q) + $signed({{(RX_W-1){1'b0}}, v_inc});
    end

    always_ff @(posedge i_clk) begin
        r_pa  <= PROD_W'(i_a) * PROD_W'(i_ka);
        r_pb  <= PROD_W'(i_b) * PROD_W'(i_kb);
        r_s1  <= i_scale;

        r_sum <= SUM_W'(r_pa) + SUM_W'(r_pb);
        r_s2  <= r_s1;

        // split the wide sum so each scale product stays narrow
        r_plo <= PLO_W'(r_s2) * PLO_W'(sum_lo);
        r_phi <= PHI_W'(r_s2) * PHI_W'(sum_hi);

        r_v   <= (PW'(r_phi) <<< LO_W) + PW'(r_plo);

        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

FILE: design/frame_transform_compose_2d.sv
// Composes a child's local 2D pose with its parent's global pose.
// Input: a pose pair is taken at each rising edge with start high and busy
// low. busy stays low, so a new pair may enter in every cycle.
// Output: one result per pair, shown for one cycle with o_strobe high once
// the pair has passed the pipeline below; the result registers load on the
// edge that raises o_strobe. Sustained rate is one item per cycle.
// The pipeline has four stages of the quarter-wave sine and cosine
// polynomial, five stages of rotate, scale and round (two products,
// sum, split scale product, recombine, round), one stage of add and clamp.
// Pairs without 2D data travel through the same pipeline and come out with
// o_updated low and every other field zero.
// The receiver cannot stall; results are never held back.
// Reset (i_rst_n low at an edge) clears all valid bits; pairs in flight are
// dropped and no strobe follows until new pairs are accepted.
`default_nettype none
module frame_transform_compose_2d import ftc_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_has_2d_data,
    input  wire logic signed [PORT_COORD_W-1:0] i_parent_x,
    input  wire logic signed [PORT_COORD_W-1:0] i_parent_y,
    input  wire logic signed [PORT_COORD_W-1:0] i_parent_z,
    input  wire logic [PORT_ANGLE_W-1:0]   i_parent_angle,
    input  wire logic signed [SCALE_W-1:0] i_parent_scale,
    input  wire logic signed [PORT_COORD_W-1:0] i_local_x,
    input  wire logic signed [PORT_COORD_W-1:0] i_local_y,
    input  wire logic signed [PORT_COORD_W-1:0] i_local_z,
    input  wire logic [PORT_ANGLE_W-1:0]   i_local_angle,
    input  wire logic signed [SCALE_W-1:0] i_local_scale,
    output logic                           o_strobe,
    output logic                           o_updated,
    output logic signed [PORT_COORD_W-1:0] o_global_x,
    output logic signed [PORT_COORD_W-1:0] o_global_y,
    output logic signed [PORT_COORD_W-1:0] o_global_z,
    output logic [PORT_ANGLE_W-1:0]        o_global_angle,
    output logic signed [SCALE_W-1:0]      o_global_scale,
    output logic                           o_overflow
);

    typedef struct packed {
        logic                          has;
        logic signed [COORD_BITS-1:0]  px;
        logic signed [COORD_BITS-1:0]  py;
        logic signed [COORD_BITS:0]    zsum;
        logic [ANGLE_BITS-1:0]         ang;
        logic signed [SPROD_W-1:0]     sprod;
        logic signed [SCALE_W-1:0]     ps;
        logic signed [COORD_BITS-1:0]  lx;
        logic signed [COORD_BITS-1:0]  ly;
    } t_side;

    typedef struct packed {
        logic   ovf;
        t_coord val;
    } t_sat;

    typedef struct packed {
        logic   ovf;
        t_scale val;
    } t_ssat;

    function automatic t_sat sat_coord(input logic signed [SAT_W-1:0] v);
        t_sat res;
        res.ovf = !((&v[SAT_W-1:COORD_BITS-1]) || !(|v[SAT_W-1:COORD_BITS-1]));
        if (res.ovf) begin
            res.val = {v[SAT_W-1], {(COORD_BITS-1){~v[SAT_W-1]}}};
        end else begin
            res.val = v[COORD_BITS-1:0];
        end
        return res;
    endfunction

    function automatic t_ssat sat_scale(input logic signed [SPROD_W-1:0] p);
        logic signed [SPROD_W-SCALE_FRAC-1:0] q;
        logic                                 inc;
        logic signed [SPROD_W-SCALE_FRAC:0]   r;
        t_ssat                                res;
        q   = p[SPROD_W-1:SCALE_FRAC];
        inc = p[SCALE_FRAC-1] & ((|p[SCALE_FRAC-2:0]) | q[0]);
        r   = (SPROD_W-SCALE_FRAC+1)'(q)
              + $signed({{(SPROD_W-SCALE_FRAC){1'b0}}, inc});
        res.ovf = !((&r[SPROD_W-SCALE_FRAC:SCALE_W-1])
                    || !(|r[SPROD_W-SCALE_FRAC:SCALE_W-1]));
        if (res.ovf) begin
            res.val = {r[SPROD_W-SCALE_FRAC], {(SCALE_W-1){~r[SPROD_W-SCALE_FRAC]}}};
        end else begin
            res.val = r[SCALE_W-1:0];
        end
        return res;
    endfunction

    logic                   accept;
    logic [15:0]            angle16;
    t_side                  n_side;
    t_side                  r_side [SIDE_DEPTH];
    logic [SIDE_DEPTH-1:0]  r_vld;
    t_trig                  sin_q;
    t_trig                  cos_q;
    t_trig                  nsin_q;
    t_rot                   rot_x;
    t_rot                   rot_y;
    t_side                  sd;
    t_sat                   sat_x;
    t_sat                   sat_y;
    t_sat                   sat_z;
    t_ssat                  sat_s;

    logic                   r_strobe;
    logic                   r_updated;
    t_coord                 r_gx;
    t_coord                 r_gy;
    t_coord                 r_gz;
    logic [ANGLE_BITS-1:0]  r_ang;
    t_scale                 r_gs;
    logic                   r_ovf;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign angle16 = 16'(i_parent_angle[ANGLE_BITS-1:0]) << (16 - ANGLE_BITS);

    always_comb begin
        n_side.has   = i_has_2d_data;
        n_side.px    = $signed(i_parent_x[COORD_BITS-1:0]);
        n_side.py    = $signed(i_parent_y[COORD_BITS-1:0]);
        n_side.zsum  = (COORD_BITS+1)'($signed(i_parent_z[COORD_BITS-1:0]))
                       + (COORD_BITS+1)'($signed(i_local_z[COORD_BITS-1:0]));
        n_side.ang   = i_parent_angle[ANGLE_BITS-1:0] + i_local_angle[ANGLE_BITS-1:0];
        n_side.sprod = SPROD_W'(i_parent_scale) * SPROD_W'(i_local_scale);
        n_side.ps    = i_parent_scale;
        n_side.lx    = $signed(i_local_x[COORD_BITS-1:0]);
        n_side.ly    = $signed(i_local_y[COORD_BITS-1:0]);
    end

    ftc_sincos u_sincos (
        .i_clk   (i_clk),
        .i_angle (angle16),
        .o_sin   (sin_q),
        .o_cos   (cos_q)
    );

    assign nsin_q = -sin_q;

    // x: lx*cos - ly*sin
    ftc_rotate u_rot_x (
        .i_clk   (i_clk),
        .i_a     (r_side[ROT_TAP].lx),
        .i_b     (r_side[ROT_TAP].ly),
        .i_ka    (cos_q),
        .i_kb    (nsin_q),
        .i_scale (r_side[ROT_TAP].ps),
        .o_res   (rot_x)
    );

    // y: lx*sin + ly*cos
    ftc_rotate u_rot_y (
        .i_clk   (i_clk),
        .i_a     (r_side[ROT_TAP].lx),
        .i_b     (r_side[ROT_TAP].ly),
        .i_ka    (sin_q),
        .i_kb    (cos_q),
        .i_scale (r_side[ROT_TAP].ps),
        .o_res   (rot_y)
    );

    always_comb begin
        sd    = r_side[SIDE_DEPTH-1];
        sat_x = sat_coord(SAT_W'(rot_x) + SAT_W'(sd.px));
        sat_y = sat_coord(SAT_W'(rot_y) + SAT_W'(sd.py));
        sat_z = sat_coord(SAT_W'(sd.zsum));
        sat_s = sat_scale(sd.sprod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_strobe  <= 1'b0;
            r_updated <= 1'b0;
        end else begin
            r_vld     <= {r_vld[SIDE_DEPTH-2:0], accept};
            r_strobe  <= r_vld[SIDE_DEPTH-1];
            r_updated <= r_vld[SIDE_DEPTH-1] && sd.has;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        for (int i = 1; i < SIDE_DEPTH; i++) begin
            r_side[i] <= r_side[i-1];
        end
        // zero the whole beat when the child has no 2D data
        if (sd.has) begin
            r_gx  <= sat_x.val;
            r_gy  <= sat_y.val;
            r_gz  <= sat_z.val;
            r_ang <= sd.ang;
            r_gs  <= sat_s.val;
            r_ovf <= sat_x.ovf || sat_y.ovf || sat_z.ovf || sat_s.ovf;
        end else begin
            r_gx  <= '0;
            r_gy  <= '0;
            r_gz  <= '0;
            r_ang <= '0;
            r_gs  <= '0;
            r_ovf <= 1'b0;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_updated      = r_updated;
    assign o_global_x     = PORT_COORD_W'(r_gx);
    assign o_global_y     = PORT_COORD_W'(r_gy);
    assign o_global_z     = PORT_COORD_W'(r_gz);
    assign o_global_angle = PORT_ANGLE_W'(r_ang);
    assign o_global_scale = r_gs;
    assign o_overflow     = r_ovf;

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(SIDE_DEPTH+1) o_strobe)
        else $error("accepted beat did not come out after the pipeline depth");

    a_upd_strobe : assert property (@(posedge i_clk)
        !o_strobe |-> !o_updated)
        else $error("updated flag without a result strobe");

    a_no_data_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_updated) |-> (o_global_x == '0 && o_global_scale == '0
                                      && o_overflow == 1'b0))
        else $error("result without 2D data carries nonzero fields");

    a_has_tracks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_has_2d_data) |-> ##(SIDE_DEPTH+1) o_updated)
        else $error("2D data beat came out without the updated flag");

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import ftc_pkg::*;

    localparam int N_RANDOM = 1000;
    localparam bit [15:0] QUARTER_TURN = 16'd16384;

    typedef struct {
        logic             has_2d;
        t_coord           px;
        t_coord           py;
        t_coord           pz;
        logic [15:0]      pa;
        t_scale           ps;
        t_coord           lx;
        t_coord           ly;
        t_coord           lz;
        logic [15:0]      la;
        t_scale           ls;
    } t_pose_pair;

    typedef struct {
        logic             updated;
        t_coord           gx;
        t_coord           gy;
        t_coord           gz;
        logic [15:0]      ga;
        t_scale           gs;
        logic             ovf;
    } t_global_pose;

    class pose_scoreboard;
        t_global_pose expected_poses[$];
        int fails;
        int pairs;
        int bare_pairs;
        int saturated;

        function longint quarter_wave(longint r);
            longint x2, u, w;
            x2 = (r * r + 8192) >>> 14;
            u  = 21024 - ((2320 * x2 + 8192) >>> 14);
            w  = 51472 - ((u * x2 + 8192) >>> 14);
            return (w * r + 8192) >>> 14;
        endfunction

        function longint sine16(bit [15:0] a16);
            longint rem, mag;
            rem = a16[13:0];
            mag = a16[14] ? quarter_wave(16384 - rem) : quarter_wave(rem);
            return a16[15] ? -mag : mag;
        endfunction

        // floor division by 2^sh, then round half to even
        function longint round_even(longint v, int sh);
            longint q, rem, half;
            q    = v >>> sh;
            rem  = v - (q <<< sh);
            half = longint'(1) <<< (sh - 1);
            if (rem > half || (rem == half && q[0]))
                q++;
            return q;
        endfunction

        function longint saturate(longint v, longint lo, longint hi, inout bit ovf);
            if (v > hi) begin
                ovf = 1'b1;
                return hi;
            end
            if (v < lo) begin
                ovf = 1'b1;
                return lo;
            end
            return v;
        endfunction

        function t_global_pose compose_pose(t_pose_pair p);
            t_global_pose g;
            longint sn, cs, ps, lx, ly, rx, ry, cmax, cmin;
            bit [15:0] a16, cos_a;
            bit ovf;
            g = '{default: '0};
            if (!p.has_2d)
                return g;
            cmax  = (longint'(1) <<< (COORD_BITS - 1)) - 1;
            cmin  = -cmax - 1;
            ps    = p.ps;
            lx    = p.lx;
            ly    = p.ly;
            a16   = p.pa;
            cos_a = a16 + QUARTER_TURN;
            sn    = sine16(a16);
            cs    = sine16(cos_a);
            rx    = round_even(ps * (lx * cs - ly * sn), FRAC_BITS);
            ry    = round_even(ps * (lx * sn + ly * cs), FRAC_BITS);
            ovf   = 1'b0;
            g.updated = 1'b1;
            g.gx  = 32'(saturate(rx + longint'(p.px), cmin, cmax, ovf));
            g.gy  = 32'(saturate(ry + longint'(p.py), cmin, cmax, ovf));
            g.gz  = 32'(saturate(longint'(p.pz) + longint'(p.lz), cmin, cmax, ovf));
            g.ga  = p.pa + p.la;
            g.gs  = 16'(saturate(round_even(ps * longint'(p.ls), SCALE_FRAC),
                                 -32768, 32767, ovf));
            g.ovf = ovf;
            return g;
        endfunction

        function void note_pair(t_pose_pair p);
            t_global_pose g;
            g = compose_pose(p);
            pairs++;
            if (!p.has_2d)
                bare_pairs++;
            if (g.ovf)
                saturated++;
            expected_poses.push_back(g);
        endfunction

        function bit field_ok(string nm, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v) begin
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, nm, want_v, got_v);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_pose(t_global_pose got);
            t_global_pose want;
            bit ok;
            if (expected_poses.size() == 0) begin
                $display("%0t ns: result beat with nothing outstanding, updated %b x %h",
                         $time, got.updated, got.gx);
                fails++;
                return;
            end
            want = expected_poses.pop_front();
            ok = 1'b1;
            ok &= field_ok("updated", want.updated, got.updated);
            ok &= field_ok("global_x", want.gx, got.gx);
            ok &= field_ok("global_y", want.gy, got.gy);
            ok &= field_ok("global_z", want.gz, got.gz);
            ok &= field_ok("global_angle", want.ga, got.ga);
            ok &= field_ok("global_scale", want.gs, got.gs);
            ok &= field_ok("overflow", want.ovf, got.ovf);
            if (!ok)
                fails++;
        endfunction

        function int pending();
            return expected_poses.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_has_2d_data;
    t_coord      i_parent_x, i_parent_y, i_parent_z;
    logic [15:0] i_parent_angle;
    t_scale      i_parent_scale;
    t_coord      i_local_x, i_local_y, i_local_z;
    logic [15:0] i_local_angle;
    t_scale      i_local_scale;
    logic        o_strobe;
    logic        o_updated;
    t_coord      o_global_x, o_global_y, o_global_z;
    logic [15:0] o_global_angle;
    t_scale      o_global_scale;
    logic        o_overflow;

    pose_scoreboard pose_board = new;

    frame_transform_compose_2d u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_has_2d_data  (i_has_2d_data),
        .i_parent_x     (i_parent_x),
        .i_parent_y     (i_parent_y),
        .i_parent_z     (i_parent_z),
        .i_parent_angle (i_parent_angle),
        .i_parent_scale (i_parent_scale),
        .i_local_x      (i_local_x),
        .i_local_y      (i_local_y),
        .i_local_z      (i_local_z),
        .i_local_angle  (i_local_angle),
        .i_local_scale  (i_local_scale),
        .o_strobe       (o_strobe),
        .o_updated      (o_updated),
        .o_global_x     (o_global_x),
        .o_global_y     (o_global_y),
        .o_global_z     (o_global_z),
        .o_global_angle (o_global_angle),
        .o_global_scale (o_global_scale),
        .o_overflow     (o_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("timeout at %0t ns", $time);
        $display("frame_transform_compose_2d verification failed");
        $finish;
    end

    always @(posedge i_clk) begin : monitor
        t_pose_pair seen;
        t_global_pose got;
        if (i_rst_n === 1'b1 && o_strobe !== 1'b0) begin
            got.updated = o_updated;
            got.gx      = o_global_x;
            got.gy      = o_global_y;
            got.gz      = o_global_z;
            got.ga      = o_global_angle;
            got.gs      = o_global_scale;
            got.ovf     = o_overflow;
            pose_board.check_pose(got);
        end
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
            seen.has_2d = i_has_2d_data;
            seen.px     = i_parent_x;
            seen.py     = i_parent_y;
            seen.pz     = i_parent_z;
            seen.pa     = i_parent_angle;
            seen.ps     = i_parent_scale;
            seen.lx     = i_local_x;
            seen.ly     = i_local_y;
            seen.lz     = i_local_z;
            seen.la     = i_local_angle;
            seen.ls     = i_local_scale;
            pose_board.note_pair(seen);
        end
    end

    function automatic t_pose_pair make_pair(logic has, t_coord px, t_coord py, t_coord pz,
                                             logic [15:0] pa, t_scale ps, t_coord lx,
                                             t_coord ly, t_coord lz, logic [15:0] la,
                                             t_scale ls);
        t_pose_pair p;
        p.has_2d = has;
        p.px = px;
        p.py = py;
        p.pz = pz;
        p.pa = pa;
        p.ps = ps;
        p.lx = lx;
        p.ly = ly;
        p.lz = lz;
        p.la = la;
        p.ls = ls;
        return p;
    endfunction

    function automatic t_coord random_coord();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            3: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            4: begin
                case ($urandom_range(0, 5))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 0;
                    3: return -1;
                    4: return 32'h7FFF_FFFF - $urandom_range(0, 255);
                    default: return 32'h8000_0000 + $urandom_range(0, 255);
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic t_scale random_scale();
        case ($urandom_range(0, 5))
            0, 1, 2: return 16'(256 + $urandom_range(0, 128) - 64);
            3: return 16'($urandom);
            4: return 16'(-256 - $urandom_range(0, 64));
            default: begin
                case ($urandom_range(0, 4))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'd0;
                    3: return 16'd128;
                    default: return 16'd1;
                endcase
            end
        endcase
    endfunction

    function automatic logic [15:0] random_angle();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 4) - 2);
        return 16'($urandom);
    endfunction

    function automatic t_pose_pair random_pair();
        return make_pair($urandom_range(0, 9) != 0, random_coord(), random_coord(),
                         random_coord(), random_angle(), random_scale(), random_coord(),
                         random_coord(), random_coord(), random_angle(), random_scale());
    endfunction

    task automatic drive_fields(t_pose_pair p);
        i_has_2d_data  <= p.has_2d;
        i_parent_x     <= p.px;
        i_parent_y     <= p.py;
        i_parent_z     <= p.pz;
        i_parent_angle <= p.pa;
        i_parent_scale <= p.ps;
        i_local_x      <= p.lx;
        i_local_y      <= p.ly;
        i_local_z      <= p.lz;
        i_local_angle  <= p.la;
        i_local_scale  <= p.ls;
    endtask

    // present one beat and hold it until the block takes it
    task automatic send_pose(t_pose_pair p);
        start <= 1'b1;
        drive_fields(p);
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            start <= 1'b0;
            drive_fields(random_pair());
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (pose_board.pending() != 0);
    endtask

    initial begin : stimulus
        int sent;
        int burst;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        drive_fields(make_pair(1'b0, 0, 0, 0, 16'd0, 16'd0, 0, 0, 0, 16'd0, 16'd0));
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pose(make_pair(1'b0, -1, -1, -1, 16'hFFFF, 16'hFFFF, -1, -1, -1, 16'hFFFF,
                            16'hFFFF));
        send_pose(make_pair(1'b1, 0, 0, 0, 16'd0, 16'd0, 0, 0, 0, 16'd0, 16'd0));
        send_pose(make_pair(1'b1, 100, -200, 7, 16'd0, 16'd256, 5, 7, -3, 16'd0, 16'd256));
        send_pose(make_pair(1'b1, 10, 20, 30, 16'd16384, 16'd256, 1000, -3, 4, 16'd100,
                            16'd512));
        send_pose(make_pair(1'b1, -10, 20, 30, 16'd32768, 16'd256, 1000, -3, 4, 16'd200,
                            16'd64));
        send_pose(make_pair(1'b1, 10, -20, 30, 16'd49152, 16'd256, 1000, -3, 4, 16'd300,
                            16'hFF00));
        send_pose(make_pair(1'b1, 0, 0, 0, 16'hFFFF, 16'd256, 12345, 678, 0, 16'd1, 16'd256));
        // half-way ties on x, y and scale
        send_pose(make_pair(1'b1, 0, 0, 0, 16'd0, 16'd128, 1, 5, 0, 16'd0, 16'd1));
        send_pose(make_pair(1'b1, 0, 0, 0, 16'd0, 16'd128, 3, -5, 0, 16'd0, 16'd3));
        send_pose(make_pair(1'b1, 0, 0, 0, 16'd0, 16'd128, -1, 7, 0, 16'd0, 16'hFFFF));
        send_pose(make_pair(1'b1, 0, 0, 0, 16'd0, 16'd128, -3, -7, 0, 16'd0, 16'hFFFD));
        send_pose(make_pair(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 16'd0, 16'h7FFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 16'd0, 16'd256));
        send_pose(make_pair(1'b1, 32'h8000_0000, 32'h8000_0000, 0, 16'd0, 16'h7FFF,
                            32'h8000_0000, 32'h8000_0000, 0, 16'd0, 16'd256));
        send_pose(make_pair(1'b1, 0, 0, 32'h7FFF_FFFF, 16'd0, 16'd256, 0, 0, 1, 16'd0,
                            16'd256));
        send_pose(make_pair(1'b1, 0, 0, 32'h8000_0000, 16'd0, 16'd256, 0, 0, -1, 16'd0,
                            16'd256));
        send_pose(make_pair(1'b1, 0, 0, 0, 16'd0, 16'h7FFF, 0, 0, 0, 16'd0, 16'h7FFF));
        send_pose(make_pair(1'b1, 0, 0, 0, 16'd0, 16'h8000, 0, 0, 0, 16'd0, 16'h8000));
        send_pose(make_pair(1'b1, 0, 0, 0, 16'd0, 16'h8000, 0, 0, 0, 16'd0, 16'h7FFF));
        send_pose(make_pair(1'b1, 50, 60, 70, 16'd8192, 16'hFF00, 10, 20, 30, 16'd8192,
                            16'hFF80));
        send_pose(make_pair(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 16'd24576, 16'h8000,
                            32'h7FFF_FFFF, 32'h8000_0000, 0, 16'd40000, 16'h8000));
        send_pose(make_pair(1'b1, -1, -1, -1, 16'hFFFF, 16'hFFFF, -1, -1, -1, 16'hFFFF,
                            16'hFFFF));
        drain_results();

        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 48);
            repeat (burst) begin
                send_pose(random_pair());
                sent++;
            end
            // roughly a third of the bursts run back to back
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 7));
            if ($urandom_range(0, 24) == 0)
                drain_results();
        end
        drain_results();
        repeat (12) @(posedge i_clk);

        $display("Composed %0d pose pairs, %0d of them without 2D data;",
                 pose_board.pairs, pose_board.bare_pairs);
        $display("%0d results hit saturation, directed corners plus random bursts.",
                 pose_board.saturated);
        if (pose_board.fails == 0 && pose_board.pending() == 0) begin
            $display("frame_transform_compose_2d verification clean");
        end else begin
            if (pose_board.pending() != 0)
                $display("%0d results never arrived", pose_board.pending());
            $display("frame_transform_compose_2d verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
design/ftc_pkg.sv
design/ftc_sincos.sv
design/ftc_rotate.sv
design/frame_transform_compose_2d.sv
test/tb.sv
